FILE: rtl/core/hrhp_pkg.sv
`timescale 1ns / 1ps

package hrhp_pkg;

    localparam int DEF_COUNT_BITS      = 34;
    localparam int DEF_MAX_VALUE_CHARS = 10;

    localparam int OUT_W       = 34;
    localparam int SKIP_LEN    = 9;
    localparam int PREFIX_LEN  = 12;
    localparam int LINE_SAT    = 13;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FORBIDDEN = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_PARTIAL   = 3'd5;

    localparam logic [1:0] VM_SKIP   = 2'd0;
    localparam logic [1:0] VM_DIGITS = 2'd1;
    localparam logic [1:0] VM_STOP   = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_item;

    typedef struct packed {
        logic             body_valid;
        logic [7:0]       body_byte;
        logic             done_res;
        logic [2:0]       status;
        logic [OUT_W-1:0] content_length;
        logic [OUT_W-1:0] bytes_received;
    } t_result;

    // Header name prefix that selects the length line.
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "C";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "L";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/core/hrhp_if.sv
`timescale 1ns / 1ps

interface hrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface hrhp_out_if;
    logic        valid;
    logic        ready;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [33:0] content_length;
    logic [33:0] bytes_received;

    modport source (
        output valid, output body_valid, output body_byte, output done_res,
        output status, output content_length, output bytes_received, input ready
    );
    modport sink (
        input valid, input body_valid, input body_byte, input done_res,
        input status, input content_length, input bytes_received, output ready
    );
endinterface

FILE: rtl/core/hrhp_value.sv
`timescale 1ns / 1ps

module hrhp_value import hrhp_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic [7:0]            i_char,
    input  logic [1:0]            i_mode,
    input  logic [COUNT_BITS-1:0] i_value,
    output logic [1:0]            o_mode,
    output logic [COUNT_BITS-1:0] o_value
);

    logic                  digit;
    logic                  blank;
    logic [COUNT_BITS+3:0] v_ext;
    logic [COUNT_BITS+3:0] acc;
    logic                  sat;

    assign digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign blank = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_VT)
                || (i_char == CH_FF) || (i_char == CH_CR) || (i_char == CH_LF);
    assign v_ext = {4'b0000, i_value};
    assign acc   = (v_ext << 3) + (v_ext << 1) + {{COUNT_BITS{1'b0}}, i_char[3:0]};
    assign sat   = |acc[COUNT_BITS+3:COUNT_BITS];

    always_comb begin
        o_mode  = i_mode;
        o_value = i_value;
        case (i_mode)
            VM_SKIP: begin
                if (!blank) begin
                    if (i_char == CH_PLUS) begin
                        o_mode = VM_DIGITS;
                    end else if (digit) begin
                        o_value = {{(COUNT_BITS-4){1'b0}}, i_char[3:0]};
                        o_mode  = VM_DIGITS;
                    end else begin
                        o_mode = VM_STOP;
                    end
                end
            end
            VM_DIGITS: begin
                if (digit) begin
                    o_value = sat ? {COUNT_BITS{1'b1}} : acc[COUNT_BITS-1:0];
                end else begin
                    o_mode = VM_STOP;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/hrhp_engine.sv
`timescale 1ns / 1ps

module hrhp_engine import hrhp_pkg::*; #(
    parameter int COUNT_BITS      = DEF_COUNT_BITS,
    parameter int MAX_VALUE_CHARS = DEF_MAX_VALUE_CHARS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int VC_BITS = $clog2(MAX_VALUE_CHARS + 3);
    localparam logic [VC_BITS-1:0] VC_SAT  = VC_BITS'(MAX_VALUE_CHARS + 2);
    localparam logic [VC_BITS-1:0] VC_OVER = VC_BITS'(MAX_VALUE_CHARS + 1);

    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_HEADER = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_DRAIN  = 3'd4;

    logic [2:0]            r_phase,       n_phase;
    logic [3:0]            r_phase_count, n_phase_count;
    logic [15:0]           r_status_digits, n_status_digits;
    logic [3:0]            r_line_pos,    n_line_pos;
    logic                  r_prefix_match, n_prefix_match;
    logic                  r_colon_seen,  n_colon_seen;
    logic [VC_BITS-1:0]    r_value_chars, n_value_chars;
    logic [1:0]            r_value_mode,  n_value_mode;
    logic [COUNT_BITS-1:0] r_value_now,   n_value_now;
    logic [COUNT_BITS-1:0] r_value_prev,  n_value_prev;
    logic [COUNT_BITS-1:0] r_length,      n_length;
    logic [COUNT_BITS-1:0] r_body_count,  n_body_count;

    logic [7:0]            c;
    logic [1:0]            fed_mode;
    logic [COUNT_BITS-1:0] fed_value;
    logic                  mismatch;
    logic [3:0]            line_pos_inc;
    logic                  length_line;
    logic                  too_long;
    logic [2:0]            klass;
    logic [COUNT_BITS-1:0] len_out_src;
    logic [COUNT_BITS-1:0] cnt_out_src;
    logic [OUT_W+COUNT_BITS-1:0] len_wide;
    logic [OUT_W+COUNT_BITS-1:0] cnt_wide;

    function automatic logic [2:0] classify(input logic [15:0] first_two,
                                            input logic [7:0] third);
        logic [2:0] k;
        k = ST_UNKNOWN;
        if (first_two[15:8] == "2" && first_two[7:0] == "0"
                && (third == "0" || third == "6")) begin
            k = ST_OK;
        end else if (first_two[15:8] == "4" && first_two[7:0] == "0") begin
            if (third == "3") begin
                k = ST_FORBIDDEN;
            end else if (third == "4") begin
                k = ST_NOT_FOUND;
            end
        end
        return k;
    endfunction

    assign c = i_item.in_byte;

    hrhp_value #(
        .COUNT_BITS(COUNT_BITS)
    ) u_value (
        .i_char  (c),
        .i_mode  (r_value_mode),
        .i_value (r_value_now),
        .o_mode  (fed_mode),
        .o_value (fed_value)
    );

    assign mismatch     = (r_line_pos < 4'(PREFIX_LEN)) && (c != prefix_char(r_line_pos));
    assign line_pos_inc = (r_line_pos < 4'(LINE_SAT)) ? r_line_pos + 4'd1 : r_line_pos;
    assign length_line  = r_colon_seen && (r_line_pos >= 4'(LINE_SAT)) && r_prefix_match;
    assign too_long     = (r_value_chars == '0) || (r_value_chars > VC_OVER);
    assign klass        = classify(r_status_digits, c);

    always_comb begin
        n_phase         = r_phase;
        n_phase_count   = r_phase_count;
        n_status_digits = r_status_digits;
        n_line_pos      = r_line_pos;
        n_prefix_match  = r_prefix_match;
        n_colon_seen    = r_colon_seen;
        n_value_chars   = r_value_chars;
        n_value_mode    = r_value_mode;
        n_value_now     = r_value_now;
        n_value_prev    = r_value_prev;
        n_length        = r_length;
        n_body_count    = r_body_count;

        o_result.body_valid = 1'b0;
        o_result.body_byte  = 8'h00;
        o_result.done_res   = 1'b0;
        o_result.status     = ST_OK;
        len_out_src         = n_length;
        cnt_out_src         = n_body_count;

        if (i_item.end_of_stream) begin
            if (r_phase == PH_SKIP || r_phase == PH_STATUS) begin
                o_result.done_res = 1'b1;
                o_result.status   = ST_PARTIAL;
            end else if (r_phase == PH_HEADER || r_phase == PH_BODY) begin
                o_result.done_res = 1'b1;
                o_result.status   = (r_body_count < r_length) ? ST_PARTIAL : ST_OK;
            end
            len_out_src     = r_length;
            cnt_out_src     = r_body_count;
            n_phase         = PH_SKIP;
            n_phase_count   = '0;
            n_status_digits = '0;
            n_line_pos      = '0;
            n_prefix_match  = 1'b1;
            n_colon_seen    = 1'b0;
            n_value_chars   = '0;
            n_value_mode    = VM_SKIP;
            n_value_now     = '0;
            n_value_prev    = '0;
            n_length        = '0;
            n_body_count    = '0;
        end else begin
            case (r_phase)
                PH_SKIP: begin
                    if (r_phase_count == 4'(SKIP_LEN - 1)) begin
                        n_phase       = PH_STATUS;
                        n_phase_count = '0;
                    end else begin
                        n_phase_count = r_phase_count + 4'd1;
                    end
                end
                PH_STATUS: begin
                    if (r_phase_count < 4'd2) begin
                        n_status_digits = {r_status_digits[7:0], c};
                        n_phase_count   = r_phase_count + 4'd1;
                    end else begin
                        n_phase_count = '0;
                        if (klass == ST_OK) begin
                            n_phase        = PH_HEADER;
                            n_line_pos     = '0;
                            n_prefix_match = 1'b1;
                            n_colon_seen   = 1'b0;
                            n_value_chars  = '0;
                            n_value_mode   = VM_SKIP;
                            n_value_now    = '0;
                            n_value_prev   = '0;
                        end else begin
                            n_phase           = PH_DRAIN;
                            o_result.done_res = 1'b1;
                            o_result.status   = klass;
                        end
                    end
                end
                PH_HEADER: begin
                    if (!r_colon_seen && c == CH_COLON) begin
                        n_colon_seen = 1'b1;
                        n_line_pos   = line_pos_inc;
                        if (mismatch) begin
                            n_prefix_match = 1'b0;
                        end
                    end else if (c == CH_LF) begin
                        if (length_line && too_long) begin
                            n_phase           = PH_DRAIN;
                            o_result.done_res = 1'b1;
                            o_result.status   = ST_OVERFLOW;
                        end else begin
                            if (length_line) begin
                                n_length = r_value_prev;
                            end
                            if (r_line_pos < 4'd2 && !r_colon_seen) begin
                                n_phase = PH_BODY;
                            end
                        end
                        n_line_pos     = '0;
                        n_prefix_match = 1'b1;
                        n_colon_seen   = 1'b0;
                        n_value_chars  = '0;
                        n_value_mode   = VM_SKIP;
                        n_value_now    = '0;
                        n_value_prev   = '0;
                    end else begin
                        n_line_pos = line_pos_inc;
                        if (mismatch) begin
                            n_prefix_match = 1'b0;
                        end
                        if (r_colon_seen) begin
                            if (r_value_chars < VC_SAT) begin
                                n_value_chars = r_value_chars + VC_BITS'(1);
                            end
                            n_value_prev = r_value_now;
                            n_value_mode = fed_mode;
                            n_value_now  = fed_value;
                        end
                    end
                end
                PH_BODY: begin
                    o_result.body_valid = 1'b1;
                    o_result.body_byte  = c;
                    if (r_body_count != {COUNT_BITS{1'b1}}) begin
                        n_body_count = r_body_count + COUNT_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
            len_out_src = n_length;
            cnt_out_src = n_body_count;
        end

        len_wide = {{OUT_W{1'b0}}, len_out_src};
        cnt_wide = {{OUT_W{1'b0}}, cnt_out_src};
        o_result.content_length = len_wide[OUT_W-1:0];
        o_result.bytes_received = cnt_wide[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SKIP;
            r_phase_count   <= '0;
            r_status_digits <= '0;
            r_line_pos      <= '0;
            r_prefix_match  <= 1'b1;
            r_colon_seen    <= 1'b0;
            r_value_chars   <= '0;
            r_value_mode    <= VM_SKIP;
            r_value_now     <= '0;
            r_value_prev    <= '0;
            r_length        <= '0;
            r_body_count    <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_phase_count   <= n_phase_count;
            r_status_digits <= n_status_digits;
            r_line_pos      <= n_line_pos;
            r_prefix_match  <= n_prefix_match;
            r_colon_seen    <= n_colon_seen;
            r_value_chars   <= n_value_chars;
            r_value_mode    <= n_value_mode;
            r_value_now     <= n_value_now;
            r_value_prev    <= n_value_prev;
            r_length        <= n_length;
            r_body_count    <= n_body_count;
        end
    end

endmodule

FILE: rtl/core/http_response_header_parser_top.sv
// Path: a word accepted into the input register is processed by the engine, and
// its result word is captured in the result register once that register is free.
// Throughput: one word per cycle while the output is not stalled; the input register
// and the result register form a two-stage pipeline, so input is still taken while a
// result waits downstream if the input register is empty. Reset: i_rst_n is
// synchronous and active low; it empties both stages and returns the parser to the start of a response.
`timescale 1ns / 1ps

module http_response_header_parser_top import hrhp_pkg::*; #(
    parameter int COUNT_BITS      = DEF_COUNT_BITS,
    parameter int MAX_VALUE_CHARS = DEF_MAX_VALUE_CHARS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrhp_in_if.sink     i_in,
    hrhp_out_if.source  o_out
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    step;
    t_result result;

    assign out_free = !r_out_valid || o_out.ready;
    assign step     = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    hrhp_engine #(
        .COUNT_BITS      (COUNT_BITS),
        .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.in_byte       <= i_in.in_byte;
            r_in.end_of_stream <= i_in.end_of_stream;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.body_valid     = r_out.body_valid;
    assign o_out.body_byte      = r_out.body_byte;
    assign o_out.done_res       = r_out.done_res;
    assign o_out.status         = r_out.status;
    assign o_out.content_length = r_out.content_length;
    assign o_out.bytes_received = r_out.bytes_received;

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.done_res || o_out.status == ST_OK))
        else $error("status reported without done_res");

    a_body_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.body_valid) |-> !o_out.done_res)
        else $error("body word also marked done");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while both stages are full and stalled");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result register empty after a step");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import hrhp_pkg::*;

    localparam longint unsigned COUNT_MAX = (64'd1 << DEF_COUNT_BITS) - 64'd1;
    localparam int ITEM_TARGET = 1500;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        PH_PREFIX, PH_CODE, PH_FIELDS, PH_PAYLOAD, PH_DRAIN
    } resp_stage_e;

    class response_parse_tracker;
        resp_stage_e     stage;
        int unsigned     stage_count;
        logic [15:0]     code_digits;
        int unsigned     line_pos;
        bit              name_ok;
        bit              colon;
        int unsigned     val_chars;
        logic [1:0]      val_mode;
        longint unsigned val_now;
        longint unsigned val_prev;
        longint unsigned length_reg;
        longint unsigned body_cnt;
        string           name_head;
        t_result         results_due[$];

        function new();
            name_head = "Content-Leng";
            restart();
        endfunction

        function void clear_line();
            line_pos  = 0;
            name_ok   = 1;
            colon     = 0;
            val_chars = 0;
            val_mode  = VM_SKIP;
            val_now   = 0;
            val_prev  = 0;
        endfunction

        function void restart();
            stage       = PH_PREFIX;
            stage_count = 0;
            code_digits = '0;
            clear_line();
            length_reg  = 0;
            body_cnt    = 0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void note_name_char(logic [7:0] c);
            if (line_pos < PREFIX_LEN && c != name_head[line_pos]) name_ok = 0;
            if (line_pos < LINE_SAT) line_pos++;
        endfunction

        // Skips blanks, then an optional '+' and digits; saturates at the counter width.
        function void feed_value(logic [7:0] c);
            bit              is_digit;
            longint unsigned d;
            is_digit = (c >= CH_ZERO && c <= CH_NINE);
            d = is_digit ? longint'(c - CH_ZERO) : 0;
            if (val_mode == VM_SKIP) begin
                if (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF}) return;
                if (c == CH_PLUS) begin
                    val_mode = VM_DIGITS;
                end else if (is_digit) begin
                    val_now  = d;
                    val_mode = VM_DIGITS;
                end else begin
                    val_mode = VM_STOP;
                end
            end else if (val_mode == VM_DIGITS) begin
                if (is_digit) begin
                    if (val_now > (COUNT_MAX - d) / 10) val_now = COUNT_MAX;
                    else val_now = val_now * 10 + d;
                end else begin
                    val_mode = VM_STOP;
                end
            end
        endfunction

        function logic [2:0] grade_status(logic [7:0] third);
            if (code_digits == {"2", "0"} && (third == "0" || third == "6")) return ST_OK;
            if (code_digits == {"4", "0"}) begin
                if (third == "3") return ST_FORBIDDEN;
                if (third == "4") return ST_NOT_FOUND;
            end
            return ST_UNKNOWN;
        endfunction

        function void take_byte(logic [7:0] c, logic eos);
            t_result    r;
            bit         closed;
            logic [2:0] grade;
            r = '0;
            if (eos) begin
                if (stage == PH_PREFIX || stage == PH_CODE) begin
                    r.done_res = 1;
                    r.status   = ST_PARTIAL;
                end else if (stage == PH_FIELDS || stage == PH_PAYLOAD) begin
                    r.done_res = 1;
                    r.status   = (body_cnt < length_reg) ? ST_PARTIAL : ST_OK;
                end
                r.content_length = length_reg[OUT_W-1:0];
                r.bytes_received = body_cnt[OUT_W-1:0];
                results_due.push_back(r);
                restart();
                return;
            end
            case (stage)
                PH_PREFIX: begin
                    stage_count++;
                    if (stage_count >= SKIP_LEN) begin
                        stage       = PH_CODE;
                        stage_count = 0;
                    end
                end
                PH_CODE: begin
                    if (stage_count < 2) begin
                        code_digits = {code_digits[7:0], c};
                        stage_count++;
                    end else begin
                        grade       = grade_status(c);
                        stage_count = 0;
                        if (grade == ST_OK) begin
                            stage = PH_FIELDS;
                            clear_line();
                        end else begin
                            stage      = PH_DRAIN;
                            r.done_res = 1;
                            r.status   = grade;
                        end
                    end
                end
                PH_FIELDS: begin
                    if (!colon && c == CH_COLON) begin
                        colon = 1;
                        note_name_char(c);
                    end else if (c == CH_LF) begin
                        closed = 0;
                        if (colon && line_pos >= LINE_SAT && name_ok) begin
                            if (val_chars == 0 || val_chars - 1 > DEF_MAX_VALUE_CHARS) begin
                                stage      = PH_DRAIN;
                                r.done_res = 1;
                                r.status   = ST_OVERFLOW;
                                closed     = 1;
                            end else begin
                                length_reg = val_prev;
                            end
                        end
                        if (!closed && line_pos < 2 && !colon) stage = PH_PAYLOAD;
                        clear_line();
                    end else begin
                        note_name_char(c);
                        if (colon) begin
                            if (val_chars < DEF_MAX_VALUE_CHARS + 2) val_chars++;
                            val_prev = val_now;
                            feed_value(c);
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r.body_valid = 1;
                    r.body_byte  = c;
                    if (body_cnt < COUNT_MAX) body_cnt++;
                end
                default: ;
            endcase
            r.content_length = length_reg[OUT_W-1:0];
            r.bytes_received = body_cnt[OUT_W-1:0];
            results_due.push_back(r);
        endfunction

        function bit match_result(t_result got, output string why);
            t_result want;
            why = "";
            if (results_due.size() == 0) begin
                why = "result word arrived with nothing expected";
                return 0;
            end
            want = results_due.pop_front();
            if (got.body_valid !== want.body_valid)
                why = {why, $sformatf(" body_valid %0b/%0b", got.body_valid, want.body_valid)};
            if (got.body_byte !== want.body_byte)
                why = {why, $sformatf(" body_byte %02h/%02h", got.body_byte, want.body_byte)};
            if (got.done_res !== want.done_res)
                why = {why, $sformatf(" done_res %0b/%0b", got.done_res, want.done_res)};
            if (got.status !== want.status)
                why = {why, $sformatf(" status %0d/%0d", got.status, want.status)};
            if (got.content_length !== want.content_length)
                why = {why, $sformatf(" content_length %0d/%0d",
                                      got.content_length, want.content_length)};
            if (got.bytes_received !== want.bytes_received)
                why = {why, $sformatf(" bytes_received %0d/%0d",
                                      got.bytes_received, want.bytes_received)};
            if (why != "") why = {"got/expected:", why};
            return why == "";
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrhp_in_if  in_bus ();
    hrhp_out_if out_bus ();

    http_response_header_parser_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    response_parse_tracker tracker = new();
    t_item stream_q[$];
    int    err_count = 0;
    int    cycle_count = 0;
    bit    long_hold_req = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        if (err_count < 50) $display("tb: mismatch: %s", msg);
        err_count++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back({b, 1'b0});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_eos();
        stream_q.push_back({8'($urandom), 1'b1});
    endtask

    task automatic compose_response();
        int              want;
        int              n;
        int              body_len;
        string           v;
        longint unsigned big;
        stream_q.delete();
        if ($urandom_range(0, 99) < 5) begin
            n = $urandom_range(1, 40);
            repeat (n) push_byte(8'($urandom));
            push_eos();
            return;
        end
        if ($urandom_range(0, 3) == 0) repeat (SKIP_LEN) push_byte(8'($urandom));
        else push_text("HTTP/1.0 ");
        case ($urandom_range(0, 9))
            0: push_text("403");
            1: push_text("404");
            2: repeat (3) push_byte(8'($urandom_range(8'h2F, 8'h3A)));
            3: push_text("500");
            4: push_text("206");
            default: push_text("200");
        endcase
        want = -1;
        n = $urandom_range(0, 4);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    case ($urandom_range(0, 7))
                        4: push_text("Content-Leng");
                        5: push_text("content-length");
                        6: push_text("Content-Lengthy");
                        7: push_text("Content-Len");
                        default: push_text("Content-Length");
                    endcase
                    push_byte(CH_COLON);
                    case ($urandom_range(0, 9))
                        0, 1, 2: begin
                            want = $urandom_range(0, 40);
                            v = $sformatf(" %0d", want);
                        end
                        3: begin
                            want = $urandom_range(0, 40);
                            v = $sformatf("%c%c%c +%0d", CH_TAB, CH_VT, CH_FF, want);
                        end
                        4: v = $sformatf("-%0d", $urandom_range(1, 99));
                        5: v = "";
                        6: begin
                            big = {$urandom, $urandom};
                            v = $sformatf("%0d", big % 64'd10000000000);
                        end
                        7: v = $sformatf("%0d%0d", $urandom_range(100000, 999999),
                                         $urandom_range(100000, 999999));
                        8: begin
                            want = $urandom_range(0, 40);
                            v = $sformatf(" %0dz9", want);
                        end
                        default: v = " abc";
                    endcase
                    push_text(v);
                end
                6, 7: push_text("Server: tiny");
                8: begin
                    body_len = $urandom_range(0, 15);
                    repeat (body_len) push_byte(8'($urandom));
                end
                default: push_text("Content-Length 12");
            endcase
            if ($urandom_range(0, 9) == 0) begin
                push_byte(CH_LF);
            end else begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
        end
        case ($urandom_range(0, 9))
            0: push_byte(CH_LF);
            1: begin
                push_byte("x");
                push_byte(CH_LF);
            end
            default: begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
        endcase
        if (want >= 0 && $urandom_range(0, 3) != 0) begin
            body_len = want + $urandom_range(0, 6) - 3;
            if (body_len < 0) body_len = 0;
        end else begin
            body_len = $urandom_range(0, 30);
        end
        repeat (body_len) push_byte(8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(0, stream_q.size());
            while (stream_q.size() > n) void'(stream_q.pop_back());
        end
        push_eos();
    endtask

    task automatic send_word(input t_item w, input bit with_gaps);
        int gap;
        gap = 0;
        if (with_gaps && $urandom_range(0, 99) < 25)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.in_byte       <= w.in_byte;
        in_bus.end_of_stream <= w.end_of_stream;
        do @(posedge i_clk); while (!in_bus.ready);
        tracker.take_byte(w.in_byte, w.end_of_stream);
    endtask

    task automatic send_stream(input bit with_gaps);
        foreach (stream_q[i]) send_word(stream_q[i], with_gaps);
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        string   why;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.body_valid     = out_bus.body_valid;
            got.body_byte      = out_bus.body_byte;
            got.done_res       = out_bus.done_res;
            got.status         = out_bus.status;
            got.content_length = out_bus.content_length;
            got.bytes_received = out_bus.bytes_received;
            if (!tracker.match_result(got, why)) report(why);
        end
    end

    initial begin
        int hold;
        bit calm;
        bit held_long;
        calm      = 0;
        held_long = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) calm = !calm;
            if (long_hold_req && !held_long) begin
                held_long = 1;
                out_bus.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 99) < 30) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
                out_bus.ready <= 1'b0;
                repeat (hold - 1) @(posedge i_clk);
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        int sent;
        bit hold_asked;
        bit pause_done;
        sent       = 0;
        hold_asked = 0;
        pause_done = 0;
        in_bus.valid         <= 1'b0;
        in_bus.in_byte       <= 8'h00;
        in_bus.end_of_stream <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The stream closes inside the prefix, then a not-found status is drained.
        stream_q.delete();
        push_byte(8'h00);
        push_byte(8'hFF);
        stream_q.push_back({8'hFF, 1'b1});
        push_text("HTTP/1.0 404");
        push_byte(8'h80);
        push_eos();
        sent += stream_q.size();
        send_stream(1'b0);

        while (sent < ITEM_TARGET) begin
            compose_response();
            sent += stream_q.size();
            send_stream($urandom_range(0, 3) != 0);
            if (!hold_asked && sent >= 400) begin
                hold_asked    = 1;
                long_hold_req = 1;
            end
            if (!pause_done && sent >= 1000) begin
                pause_done = 1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_if.sv
rtl/core/hrhp_value.sv
rtl/core/hrhp_engine.sv
rtl/core/http_response_header_parser_top.sv
bench/tb.sv
